FILE: rtl/smm_pkg.sv
package smm_pkg;

  localparam int MAX_SIZE      = 8;
  localparam int ELEMENT_WIDTH = 32;
  localparam int IN_WIDTH      = 32;
  localparam int ACC_WIDTH     = 64;
  localparam int SIZE_WIDTH    = 4;
  localparam int STORE_DEPTH   = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_WIDTH    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int IDX_WIDTH     = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int DIM_WIDTH     = $clog2(MAX_SIZE + 1);
  localparam int TOTAL_WIDTH   = $clog2(STORE_DEPTH + 1);
  localparam logic [SIZE_WIDTH-1:0] SIZE_RESET = SIZE_WIDTH'(8);

  typedef struct packed {
    logic                  wr_en;
    logic [ADDR_WIDTH-1:0] wr_addr;
    logic                  rd_en;
    logic [ADDR_WIDTH-1:0] a_rd_addr;
    logic [ADDR_WIDTH-1:0] b_rd_addr;
    logic                  first;
    logic                  last_k;
    logic                  last_elem;
  } smm_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } smm_status_t;

  function automatic logic [DIM_WIDTH-1:0] clamp_dim(input logic [SIZE_WIDTH-1:0] size);
    logic [DIM_WIDTH-1:0] dim;
    if (size == '0) begin
      dim = DIM_WIDTH'(1);
    end else if (size > SIZE_WIDTH'(MAX_SIZE)) begin
      dim = DIM_WIDTH'(MAX_SIZE);
    end else begin
      dim = DIM_WIDTH'(size);
    end
    return dim;
  endfunction

endpackage

FILE: rtl/smm_ram.sv
module smm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/smm_ctrl.sv
module smm_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 cfg_valid,
  input  logic [smm_pkg::SIZE_WIDTH-1:0]       cfg_size_in_use,
  input  smm_pkg::smm_status_t                 status,
  output logic                                 busy,
  output logic                                 cfg_ready,
  output smm_pkg::smm_cmd_t                    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } smm_state_t;

  smm_state_t state_r, state_nxt;
  logic [smm_pkg::SIZE_WIDTH-1:0] size_r, size_nxt;
  logic [smm_pkg::ADDR_WIDTH-1:0] load_cnt_r, load_cnt_nxt;
  logic [smm_pkg::IDX_WIDTH-1:0]  k_r, k_nxt, c_r, c_nxt, r_r, r_nxt;
  logic [smm_pkg::ADDR_WIDTH-1:0] a_addr_r, a_addr_nxt, b_addr_r, b_addr_nxt;
  logic [smm_pkg::ADDR_WIDTH-1:0] row_base_r, row_base_nxt;
  logic [smm_pkg::DIM_WIDTH-1:0]  dim;
  logic [smm_pkg::IDX_WIDTH-1:0]  dim_last;
  logic [smm_pkg::ADDR_WIDTH-1:0] dim_addr;
  logic [smm_pkg::TOTAL_WIDTH-1:0] total;
  logic k_end, c_end, r_end;

  assign dim      = smm_pkg::clamp_dim(size_r);
  assign dim_last = smm_pkg::IDX_WIDTH'(dim - smm_pkg::DIM_WIDTH'(1));
  assign dim_addr = smm_pkg::ADDR_WIDTH'(dim);
  assign total    = smm_pkg::TOTAL_WIDTH'(dim) * smm_pkg::TOTAL_WIDTH'(dim);
  assign k_end    = (k_r == dim_last);
  assign c_end    = (c_r == dim_last);
  assign r_end    = (r_r == dim_last);

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE) && !start;

  always_comb begin
    state_nxt    = state_r;
    size_nxt     = size_r;
    load_cnt_nxt = load_cnt_r;
    k_nxt        = k_r;
    c_nxt        = c_r;
    r_nxt        = r_r;
    a_addr_nxt   = a_addr_r;
    b_addr_nxt   = b_addr_r;
    row_base_nxt = row_base_r;
    cmd          = '0;

    if (cfg_valid && cfg_ready && (load_cnt_r == '0)) begin
      size_nxt = cfg_size_in_use;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_addr = load_cnt_r;
          if ((smm_pkg::TOTAL_WIDTH'(load_cnt_r) + smm_pkg::TOTAL_WIDTH'(1)) == total) begin
            load_cnt_nxt = '0;
            k_nxt        = '0;
            c_nxt        = '0;
            r_nxt        = '0;
            a_addr_nxt   = '0;
            b_addr_nxt   = '0;
            row_base_nxt = '0;
            state_nxt    = ST_RUN;
          end else begin
            load_cnt_nxt = load_cnt_r + smm_pkg::ADDR_WIDTH'(1);
          end
        end
      end
      ST_RUN: begin
        cmd.rd_en     = 1'b1;
        cmd.a_rd_addr = a_addr_r;
        cmd.b_rd_addr = b_addr_r;
        cmd.first     = (k_r == '0);
        cmd.last_k    = k_end;
        cmd.last_elem = k_end && c_end && r_end;
        if (!k_end) begin
          k_nxt      = k_r + smm_pkg::IDX_WIDTH'(1);
          a_addr_nxt = a_addr_r + smm_pkg::ADDR_WIDTH'(1);
          b_addr_nxt = b_addr_r + dim_addr;
        end else if (!c_end) begin
          k_nxt      = '0;
          c_nxt      = c_r + smm_pkg::IDX_WIDTH'(1);
          a_addr_nxt = row_base_r;
          b_addr_nxt = smm_pkg::ADDR_WIDTH'(c_r) + smm_pkg::ADDR_WIDTH'(1);
        end else if (!r_end) begin
          k_nxt        = '0;
          c_nxt        = '0;
          r_nxt        = r_r + smm_pkg::IDX_WIDTH'(1);
          row_base_nxt = row_base_r + dim_addr;
          a_addr_nxt   = row_base_r + dim_addr;
          b_addr_nxt   = '0;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      size_r     <= smm_pkg::SIZE_RESET;
      load_cnt_r <= '0;
      k_r        <= '0;
      c_r        <= '0;
      r_r        <= '0;
      a_addr_r   <= '0;
      b_addr_r   <= '0;
      row_base_r <= '0;
    end else begin
      state_r    <= state_nxt;
      size_r     <= size_nxt;
      load_cnt_r <= load_cnt_nxt;
      k_r        <= k_nxt;
      c_r        <= c_nxt;
      r_r        <= r_nxt;
      a_addr_r   <= a_addr_nxt;
      b_addr_r   <= b_addr_nxt;
      row_base_r <= row_base_nxt;
    end
  end

endmodule

FILE: rtl/smm_datapath.sv
module smm_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  smm_pkg::smm_cmd_t                    cmd,
  input  logic [smm_pkg::IN_WIDTH-1:0]         in_a_value,
  input  logic [smm_pkg::IN_WIDTH-1:0]         in_b_value,
  output smm_pkg::smm_status_t                 status,
  output logic                                 out_valid,
  output logic [smm_pkg::ACC_WIDTH-1:0]        out_c_value,
  output logic                                 out_last_of_run
);

  logic [smm_pkg::ELEMENT_WIDTH-1:0] a_rd, b_rd;
  logic signed [2*smm_pkg::ELEMENT_WIDTH-1:0] prod_full;
  logic signed [smm_pkg::ACC_WIDTH-1:0] prod_r, acc_r, acc_sum;
  logic s1_valid_r, s1_first_r, s1_last_k_r, s1_last_elem_r;
  logic s2_valid_r, s2_first_r, s2_last_k_r, s2_last_elem_r;
  logic out_valid_r, out_last_r;
  logic [smm_pkg::ACC_WIDTH-1:0] out_c_r;

  smm_ram #(
    .WIDTH (smm_pkg::ELEMENT_WIDTH),
    .DEPTH (smm_pkg::STORE_DEPTH)
  ) u_a_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cmd.wr_addr),
    .wr_data (in_a_value[smm_pkg::ELEMENT_WIDTH-1:0]),
    .rd_addr (cmd.a_rd_addr),
    .rd_data (a_rd)
  );

  smm_ram #(
    .WIDTH (smm_pkg::ELEMENT_WIDTH),
    .DEPTH (smm_pkg::STORE_DEPTH)
  ) u_b_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cmd.wr_addr),
    .wr_data (in_b_value[smm_pkg::ELEMENT_WIDTH-1:0]),
    .rd_addr (cmd.b_rd_addr),
    .rd_data (b_rd)
  );

  assign prod_full = $signed(a_rd) * $signed(b_rd);
  assign acc_sum   = s2_first_r ? prod_r : (acc_r + prod_r);

  always_ff @(posedge clk) begin
    prod_r         <= smm_pkg::ACC_WIDTH'(prod_full);
    s1_first_r     <= cmd.first;
    s1_last_k_r    <= cmd.last_k;
    s1_last_elem_r <= cmd.last_elem;
    s2_first_r     <= s1_first_r;
    s2_last_k_r    <= s1_last_k_r;
    s2_last_elem_r <= s1_last_elem_r;
    if (s2_valid_r) begin
      acc_r <= acc_sum;
    end
    if (s2_valid_r && s2_last_k_r) begin
      out_c_r <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      s1_valid_r  <= cmd.rd_en;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r && s2_last_k_r;
      out_last_r  <= s2_valid_r && s2_last_k_r && s2_last_elem_r;
    end
  end

  assign status.pipe_busy = s1_valid_r || s2_valid_r;
  assign out_valid        = out_valid_r;
  assign out_c_value      = out_c_r;
  assign out_last_of_run  = out_last_r;

endmodule

FILE: rtl/square_matrix_multiply.sv
// Channel  Handshake                 Payload
// input    start, busy               in_a_value, in_b_value
// result   out_valid (strobe)        out_c_value, out_last_of_run
// config   cfg_valid, cfg_ready      cfg_size_in_use
//
// One input transfer is taken per cycle while start is high and busy is low; the n*n-th one starts the product.
// The product runs on the single multiply-accumulate unit, one element pair read
// from each store per cycle, and is followed by a drain of the pipeline.
// Reset is synchronous and active low; the size register returns to 8.
// Busy stays high from the last load until the last result; results cannot stall.
module square_matrix_multiply (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [smm_pkg::IN_WIDTH-1:0]         in_a_value,
  input  logic [smm_pkg::IN_WIDTH-1:0]         in_b_value,
  output logic                                 out_valid,
  output logic [smm_pkg::ACC_WIDTH-1:0]        out_c_value,
  output logic                                 out_last_of_run,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [smm_pkg::SIZE_WIDTH-1:0]       cfg_size_in_use
);

  smm_pkg::smm_cmd_t    cmd;
  smm_pkg::smm_status_t status;

  smm_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .cfg_valid       (cfg_valid),
    .cfg_size_in_use (cfg_size_in_use),
    .status          (status),
    .busy            (busy),
    .cfg_ready       (cfg_ready),
    .cmd             (cmd)
  );

  smm_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_a_value      (in_a_value),
    .in_b_value      (in_b_value),
    .status          (status),
    .out_valid       (out_valid),
    .out_c_value     (out_c_value),
    .out_last_of_run (out_last_of_run)
  );

`ifndef SYNTHESIS
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a computation");

  a_last_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_of_run |-> out_valid)
    else $error("last flag without result strobe");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_run) |=> !busy)
    else $error("block still busy after the last result");

  a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (!cmd.wr_en && !cfg_ready))
    else $error("store write or configuration open during computation");
`endif

endmodule
